@@ sv/tksd_pkg.sv @@
// Shared types, codes and decode functions for the terminal key sequence decoder.
// Depends on nothing; imported by the front, back and top-level modules.
package tksd_pkg;

   localparam int NUMBER_WIDTH = 32;

   // Parser phases
   localparam logic [3:0] PH_IDLE      = 4'd0;
   localparam logic [3:0] PH_ESC       = 4'd1;
   localparam logic [3:0] PH_CSI_START = 4'd2;
   localparam logic [3:0] PH_CSI_NUM1  = 4'd3;
   localparam logic [3:0] PH_CSI_SEMI  = 4'd4;
   localparam logic [3:0] PH_CSI_NUM2  = 4'd5;
   localparam logic [3:0] PH_SS3       = 4'd6;
   localparam logic [3:0] PH_SS3_ONE   = 4'd7;
   localparam logic [3:0] PH_SS3_SEMI  = 4'd8;
   localparam logic [3:0] PH_SS3_FINAL = 4'd9;

   // Key kinds
   localparam logic [4:0] K_INV   = 5'd0;
   localparam logic [4:0] K_CHAR  = 5'd1;
   localparam logic [4:0] K_ENTER = 5'd2;
   localparam logic [4:0] K_TAB   = 5'd3;
   localparam logic [4:0] K_ESC   = 5'd4;
   localparam logic [4:0] K_BKSP  = 5'd5;
   localparam logic [4:0] K_UP    = 5'd6;
   localparam logic [4:0] K_DOWN  = 5'd7;
   localparam logic [4:0] K_RIGHT = 5'd8;
   localparam logic [4:0] K_LEFT  = 5'd9;
   localparam logic [4:0] K_HOME  = 5'd10;
   localparam logic [4:0] K_END   = 5'd11;
   localparam logic [4:0] K_INS   = 5'd12;
   localparam logic [4:0] K_DEL   = 5'd13;
   localparam logic [4:0] K_PGUP  = 5'd14;
   localparam logic [4:0] K_PGDN  = 5'd15;
   localparam logic [4:0] K_F1    = 5'd16;

   // Modifier bits
   localparam logic [2:0] M_NONE = 3'd0;
   localparam logic [2:0] M_S    = 3'd1;
   localparam logic [2:0] M_A    = 3'd2;
   localparam logic [2:0] M_C    = 3'd4;

   // Byte codes
   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_CTLA  = 8'h01;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0a;
   localparam logic [7:0] CH_CR    = 8'h0d;
   localparam logic [7:0] CH_CTLZ  = 8'h1a;
   localparam logic [7:0] CH_ESC   = 8'h1b;
   localparam logic [7:0] CH_US    = 8'h1f;
   localparam logic [7:0] CH_DEL   = 8'h7f;
   localparam logic [7:0] CH_FF    = 8'hff;
   localparam logic [7:0] CH_CTL_TO_UPPER = 8'h40;
   localparam logic [7:0] CH_CASE  = 8'h20;

   typedef logic [NUMBER_WIDTH-1:0] number_type;

   typedef struct packed {
      logic [7:0] data;
      logic       more;
      logic       is_digit;
      logic [3:0] digit;
   } item_type;

   typedef struct packed {
      logic [4:0] kind;
      logic [7:0] chv;
      logic [2:0] mods;
   } result_type;

   function automatic result_type mk_res(logic [4:0] kind, logic [7:0] chv, logic [2:0] mods);
      result_type r;
      r.kind = kind;
      r.chv  = (kind == K_CHAR) ? chv : 8'd0;
      r.mods = mods;
      return r;
   endfunction

   function automatic result_type inv_res();
      return mk_res(K_INV, 8'd0, M_NONE);
   endfunction

   function automatic logic [2:0] num_mods(number_type n);
      return n[2:0] - 3'd1;
   endfunction

   function automatic result_type csi_final(logic [7:0] ch, number_type n1, number_type n2,
                                            logic hf, logic hs);
      logic [2:0] m;
      logic       bad;
      m   = M_NONE;
      bad = 1'b0;
      if (ch == "~") begin
         if (!hf || (hs && n2 == '0)) begin
            bad = 1'b1;
         end else if (hs) begin
            m = num_mods(n2);
         end
         if (bad) return inv_res();
         if (n1 == number_type'(1) || n1 == number_type'(7)) return mk_res(K_HOME, 8'd0, m);
         if (n1 == number_type'(2) || n1 == number_type'(8)) return mk_res(K_INS, 8'd0, m);
         if (n1 == number_type'(3)) return mk_res(K_DEL, 8'd0, m);
         if (n1 == number_type'(4)) return mk_res(K_END, 8'd0, m);
         if (n1 == number_type'(5)) return mk_res(K_PGUP, 8'd0, m);
         if (n1 == number_type'(6)) return mk_res(K_PGDN, 8'd0, m);
         if (n1 >= number_type'(11) && n1 <= number_type'(15))
            return mk_res(K_F1 + n1[4:0] - 5'd11, 8'd0, m);
         if (n1 >= number_type'(17) && n1 <= number_type'(21))
            return mk_res(K_F1 + n1[4:0] - 5'd12, 8'd0, m);
         if (n1 == number_type'(23) || n1 == number_type'(24))
            return mk_res(K_F1 + n1[4:0] - 5'd13, 8'd0, m);
         return inv_res();
      end
      if (hf) begin
         if (hs) begin
            if (n1 != number_type'(1) || n2 == '0) bad = 1'b1;
            else m = num_mods(n2);
         end else begin
            if (n1 == '0) bad = 1'b1;
            else m = num_mods(n1);
         end
      end
      if (bad) return inv_res();
      case (ch)
         "A":     return mk_res(K_UP, 8'd0, m);
         "B":     return mk_res(K_DOWN, 8'd0, m);
         "C":     return mk_res(K_RIGHT, 8'd0, m);
         "D":     return mk_res(K_LEFT, 8'd0, m);
         "F":     return mk_res(K_END, 8'd0, m);
         "H":     return mk_res(K_HOME, 8'd0, m);
         "Z":     return mk_res(K_TAB, 8'd0, M_S);
         default: return inv_res();
      endcase
   endfunction

   function automatic result_type ss3_letter(logic [7:0] ch, logic [2:0] m);
      case (ch)
         "F":     return mk_res(K_END, 8'd0, m);
         "H":     return mk_res(K_HOME, 8'd0, m);
         "P":     return mk_res(K_F1, 8'd0, m);
         "Q":     return mk_res(K_F1 + 5'd1, 8'd0, m);
         "R":     return mk_res(K_F1 + 5'd2, 8'd0, m);
         "S":     return mk_res(K_F1 + 5'd3, 8'd0, m);
         default: return inv_res();
      endcase
   endfunction

   // Result for a byte after ESC that closes the sequence
   function automatic result_type esc_res(logic [7:0] ch);
      if (ch == CH_ESC) return mk_res(K_ESC, 8'd0, M_NONE);
      if (ch == CH_LF) return mk_res(K_ENTER, 8'd0, M_A);
      if (ch inside {[CH_CTLA:CH_CTLZ]})
         return mk_res(K_CHAR, ch + CH_CTL_TO_UPPER, M_C | M_A);
      if (ch == CH_US) return mk_res(K_CHAR, "-", M_C | M_A | M_S);
      if (ch inside {["a":"z"]}) return mk_res(K_CHAR, ch - CH_CASE, M_A);
      if (ch == CH_DEL) return mk_res(K_BKSP, 8'd0, M_A);
      return mk_res(K_CHAR, ch, M_A);
   endfunction

   function automatic result_type idle_res(logic [7:0] ch);
      if (ch == CH_TAB) return mk_res(K_TAB, 8'd0, M_NONE);
      if (ch == CH_LF) return mk_res(K_ENTER, 8'd0, M_C);
      if (ch == CH_CR) return mk_res(K_ENTER, 8'd0, M_NONE);
      if (ch inside {[CH_CTLA:CH_CTLZ]}) return mk_res(K_CHAR, ch + CH_CTL_TO_UPPER, M_C);
      if (ch == CH_ESC) return mk_res(K_ESC, 8'd0, M_NONE);
      if (ch == CH_US) return mk_res(K_CHAR, "-", M_C | M_A);
      if (ch == CH_DEL) return mk_res(K_BKSP, 8'd0, M_NONE);
      if (ch == CH_NUL || ch == CH_FF) return inv_res();
      return mk_res(K_CHAR, ch, M_NONE);
   endfunction

endpackage

@@ sv/terminal_key_sequence_decoder_top.sv @@
// Top level of the terminal key sequence decoder: front queue feeding the parser.
// Depends on tksd_pkg, tksd_front and tksd_back.
//
//   channel   direction  handshake       payload
//   req_      in         push / full     in_byte[7:0], more_pending
//   rsp_      out        pop / empty     key_kind[4:0], char_value[7:0], mod_shift/alt/ctrl
//
// One byte per cycle sustained while the result side keeps popping; the parser register update sets that figure.
// A result passes through the byte queue and the parser into the result queue before it reaches
// rsp_ and can be popped; each side has a 2-entry queue.
// Reset clears both queues and returns the parser to idle.
// A stalled result side fills the result queue, then the byte queue, then raises full.
module terminal_key_sequence_decoder_top (
   input  logic       clock,
   input  logic       reset,
   input  logic [7:0] req_in_byte,
   input  logic       req_more_pending,
   input  logic       req_push,
   output logic       req_full,
   output logic [4:0] rsp_key_kind,
   output logic [7:0] rsp_char_value,
   output logic       rsp_mod_shift,
   output logic       rsp_mod_alt,
   output logic       rsp_mod_ctrl,
   output logic       rsp_empty,
   input  logic       rsp_pop
);
   import tksd_pkg::*;

   logic       item_valid;
   logic       item_take;
   item_type   item;
   result_type res;

   tksd_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_in_byte      (req_in_byte),
      .req_more_pending (req_more_pending),
      .req_push         (req_push),
      .req_full         (req_full),
      .item_valid       (item_valid),
      .item             (item),
      .item_take        (item_take)
   );

   tksd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item       (item),
      .item_take  (item_take),
      .res        (res),
      .res_empty  (rsp_empty),
      .res_pop    (rsp_pop)
   );

   assign rsp_key_kind   = res.kind;
   assign rsp_char_value = res.chv;
   assign rsp_mod_shift  = res.mods[0];
   assign rsp_mod_alt    = res.mods[1];
   assign rsp_mod_ctrl   = res.mods[2];

endmodule

@@ sv/tksd_front.sv @@
// Front end: takes request bytes, tags digits and holds them in a two-entry queue.
// Depends on tksd_pkg.
module tksd_front (
   input  logic              clock,
   input  logic              reset,
   input  logic [7:0]        req_in_byte,
   input  logic              req_more_pending,
   input  logic              req_push,
   output logic              req_full,
   output logic              item_valid,
   output tksd_pkg::item_type item,
   input  logic              item_take
);
   import tksd_pkg::*;

   item_type   q_ff [2];
   logic       wptr_ff, wptr_in;
   logic       rptr_ff, rptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push_ok, pop_ok;
   item_type   tagged_item;

   always_comb begin
      tagged_item.data     = req_in_byte;
      tagged_item.more     = req_more_pending;
      tagged_item.is_digit = (req_in_byte inside {["0":"9"]});
      tagged_item.digit    = req_in_byte[3:0];
   end

   assign req_full   = (cnt_ff == 2'd2);
   assign item_valid = (cnt_ff != 2'd0);
   assign item       = q_ff[rptr_ff];
   assign push_ok    = req_push && !req_full;
   assign pop_ok     = item_take && item_valid;

   always_comb begin
      wptr_in = wptr_ff ^ push_ok;
      rptr_in = rptr_ff ^ pop_ok;
      cnt_in  = cnt_ff + {1'b0, push_ok} - {1'b0, pop_ok};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         cnt_ff  <= 2'd0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         q_ff[wptr_ff] <= tagged_item;
      end
   end

endmodule

@@ sv/tksd_back.sv @@
// Back end: sequence parser that consumes tagged bytes and queues key results.
// Depends on tksd_pkg.
module tksd_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               item_valid,
   input  tksd_pkg::item_type item,
   output logic               item_take,
   output tksd_pkg::result_type res,
   output logic               res_empty,
   input  logic               res_pop
);
   import tksd_pkg::*;

   logic [3:0] ph_ff, ph_in;
   number_type n1_ff, n1_in;
   number_type n2_ff, n2_in;
   logic       hf_ff, hf_in;
   logic       hs_ff, hs_in;
   logic [2:0] hm_ff, hm_in;

   result_type out_q_ff [2];
   logic       owptr_ff, orptr_ff;
   logic [1:0] ocnt_ff, ocnt_in;

   logic       fire;
   logic       emit;
   result_type r;
   logic [7:0] ch;
   logic       more;
   number_type acc1, acc2, dig;

   assign item_take = item_valid && (ocnt_ff != 2'd2);
   assign fire      = item_take;
   assign ch        = item.data;
   assign more      = item.more;
   assign dig       = number_type'(item.digit);

   // n*10 + d as two shifts and two adds
   assign acc1 = {n1_ff[NUMBER_WIDTH-4:0], 3'b000} + {n1_ff[NUMBER_WIDTH-2:0], 1'b0} + dig;
   assign acc2 = {n2_ff[NUMBER_WIDTH-4:0], 3'b000} + {n2_ff[NUMBER_WIDTH-2:0], 1'b0} + dig;

   always_comb begin
      ph_in = ph_ff;
      n1_in = n1_ff;
      n2_in = n2_ff;
      hf_in = hf_ff;
      hs_in = hs_ff;
      hm_in = hm_ff;
      emit  = 1'b0;
      r     = inv_res();
      case (ph_ff)
         PH_ESC: begin
            if (ch == "[" && more) begin
               ph_in = PH_CSI_START;
               n1_in = '0;
               n2_in = '0;
               hf_in = 1'b0;
               hs_in = 1'b0;
            end else if (ch == "O" && more) begin
               ph_in = PH_SS3;
            end else begin
               emit = 1'b1;
               r    = esc_res(ch);
            end
         end
         PH_CSI_START, PH_CSI_NUM1: begin
            if (item.is_digit) begin
               hf_in = 1'b1;
               n1_in = (ph_ff == PH_CSI_START) ? dig : acc1;
               ph_in = PH_CSI_NUM1;
               emit  = !more;
            end else if (ch == ";") begin
               if (more) begin
                  hs_in = 1'b0;
                  n2_in = '0;
                  ph_in = PH_CSI_SEMI;
               end else begin
                  emit = 1'b1;
               end
            end else begin
               emit = 1'b1;
               r    = csi_final(ch, n1_ff, n2_ff, hf_ff, hs_ff);
            end
         end
         PH_CSI_SEMI, PH_CSI_NUM2: begin
            if (item.is_digit) begin
               hs_in = 1'b1;
               n2_in = (ph_ff == PH_CSI_SEMI) ? dig : acc2;
               ph_in = PH_CSI_NUM2;
               emit  = !more;
            end else begin
               emit = 1'b1;
               r    = csi_final(ch, n1_ff, n2_ff, hf_ff, hs_ff);
            end
         end
         PH_SS3: begin
            if (ch == "1" && more) begin
               ph_in = PH_SS3_ONE;
            end else if (ch == "1") begin
               emit = 1'b1;
            end else begin
               emit = 1'b1;
               r    = ss3_letter(ch, M_NONE);
            end
         end
         PH_SS3_ONE: begin
            if (ch == ";" && more) ph_in = PH_SS3_SEMI;
            else emit = 1'b1;
         end
         PH_SS3_SEMI: begin
            if (ch >= "1") begin
               hm_in = ch[2:0] - 3'd1;
               if (more) ph_in = PH_SS3_FINAL;
               else emit = 1'b1;
            end else begin
               emit = 1'b1;
            end
         end
         PH_SS3_FINAL: begin
            emit = 1'b1;
            r    = ss3_letter(ch, hm_ff);
         end
         default: begin
            if (ch == CH_ESC && more) begin
               ph_in = PH_ESC;
            end else begin
               emit = 1'b1;
               r    = idle_res(ch);
            end
         end
      endcase
      if (emit) ph_in = PH_IDLE;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ph_ff <= PH_IDLE;
         n1_ff <= '0;
         n2_ff <= '0;
         hf_ff <= 1'b0;
         hs_ff <= 1'b0;
         hm_ff <= M_NONE;
      end else if (fire) begin
         ph_ff <= ph_in;
         n1_ff <= n1_in;
         n2_ff <= n2_in;
         hf_ff <= hf_in;
         hs_ff <= hs_in;
         hm_ff <= hm_in;
      end
   end

   // Result queue: parts the parser from the consumer
   assign res_empty = (ocnt_ff == 2'd0);
   assign res       = out_q_ff[orptr_ff];
   assign ocnt_in   = ocnt_ff + {1'b0, fire && emit} - {1'b0, res_pop && !res_empty};

   always_ff @(posedge clock) begin
      if (reset) begin
         owptr_ff <= 1'b0;
         orptr_ff <= 1'b0;
         ocnt_ff  <= 2'd0;
      end else begin
         owptr_ff <= owptr_ff ^ (fire && emit);
         orptr_ff <= orptr_ff ^ (res_pop && !res_empty);
         ocnt_ff  <= ocnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire && emit) begin
         out_q_ff[owptr_ff] <= r;
      end
   end

endmodule
